[rtl/core/oaie_pkg.sv]
package oaie_pkg;

  localparam int DEPTH     = 16;
  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 3;
  localparam int POS_W     = 4;
  localparam int CNT_OUT_W = 5;
  localparam int ST_W      = 2;

  typedef enum logic [FUNC_W-1:0] {
    F_PUSH   = 3'd0,
    F_POP    = 3'd1,
    F_INSERT = 3'd2,
    F_ERASE  = 3'd3,
    F_READ   = 3'd4,
    F_FRONT  = 3'd5,
    F_BACK   = 3'd6,
    F_CLEAR  = 3'd7
  } func_e_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADIDX = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_PUT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [CW-1:0]            count;
    status_t                  status;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;
  } ram_req_t;

endpackage

[rtl/core/oaie_if.sv]
interface oaie_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [oaie_pkg::FUNC_W-1:0]          func;
  logic [oaie_pkg::POS_W-1:0]           position;
  logic signed [oaie_pkg::DATA_W-1:0]   value;

  modport source (output valid, func, position, value, input ready);
  modport sink (input valid, func, position, value, output ready);
endinterface

interface oaie_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [oaie_pkg::DATA_W-1:0]   read_data;
  logic [oaie_pkg::CNT_OUT_W-1:0]       fill_count;
  logic [oaie_pkg::ST_W-1:0]            status;

  modport source (output valid, read_data, fill_count, status, input ready);
  modport sink (input valid, read_data, fill_count, status, output ready);
endinterface

[rtl/core/ordered_array_insert_erase_top.sv]
// Ordered array of up to 16 signed 32-bit words held in one single-port-write,
// registered-read memory, with a fill count. Each request (push, pop, insert,
// erase, read, front, back, clear) returns one result: read data (zero when
// nothing is read), the new count and a status (ok, empty, index invalid, full).
// Insert and erase shift the stored entries by one place, the memory moving
// one entry per cycle during a shift. A new request is taken once the
// previous one is done, while its result may still wait in the output register.
module ordered_array_insert_erase_top (
  input  logic       clk,
  input  logic       rst,
  oaie_req_if.sink   request,
  oaie_rsp_if.source result
);

  oaie_pkg::ram_req_t          mem_req;
  oaie_pkg::res_t              fin;
  logic [oaie_pkg::DATA_W-1:0] mem_rdata;
  logic                        fin_valid;
  logic                        fin_ready;

  oaie_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin)
  );

  oaie_ram #(
    .WIDTH (oaie_pkg::DATA_W),
    .DEPTH (oaie_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  oaie_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin),
    .result    (result)
  );

endmodule

[rtl/core/oaie_ram.sv]
module oaie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/oaie_ctrl.sv]
module oaie_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  oaie_req_if.sink                       request,
  output oaie_pkg::ram_req_t             mem_req,
  input  logic [oaie_pkg::DATA_W-1:0]    mem_rdata,
  output logic                           fin_valid,
  input  logic                           fin_ready,
  output oaie_pkg::res_t                 fin
);

  oaie_pkg::state_t  state, state_next;
  oaie_pkg::status_t status_c;
  oaie_pkg::func_e_t func_c;
  oaie_pkg::res_t    res_q;

  logic [oaie_pkg::CW-1:0]     count, count_next;
  logic [oaie_pkg::CW-1:0]     lim_q;
  logic [oaie_pkg::CW-1:0]     pos_c;
  logic [oaie_pkg::AW-1:0]     addr_q;
  logic [oaie_pkg::AW-1:0]     pos_q;
  logic [oaie_pkg::DATA_W-1:0] val_q;
  logic accept, idx_ok, full, empty, erase_more, up_more, dn_more;

  assign func_c     = oaie_pkg::func_e_t'(request.func);
  assign pos_c      = oaie_pkg::CW'(request.position);
  assign accept     = request.valid && request.ready;
  assign idx_ok     = pos_c < count;
  assign full       = count == oaie_pkg::CW'(oaie_pkg::DEPTH);
  assign empty      = count == '0;
  assign erase_more = (pos_c + oaie_pkg::CW'(1)) < count;
  assign up_more    = addr_q != pos_q;
  assign dn_more    = (oaie_pkg::CW'(addr_q) + oaie_pkg::CW'(1)) < lim_q;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      oaie_pkg::S_IDLE: begin
        if (accept) begin
          case (func_c)
            oaie_pkg::F_INSERT:
              state_next = (idx_ok && !full) ? oaie_pkg::S_SHIFT_UP : oaie_pkg::S_FINISH;
            oaie_pkg::F_ERASE:
              state_next = (idx_ok && erase_more) ? oaie_pkg::S_SHIFT_DN : oaie_pkg::S_FINISH;
            oaie_pkg::F_READ:
              state_next = idx_ok ? oaie_pkg::S_READ : oaie_pkg::S_FINISH;
            oaie_pkg::F_FRONT, oaie_pkg::F_BACK:
              state_next = !empty ? oaie_pkg::S_READ : oaie_pkg::S_FINISH;
            default:
              state_next = oaie_pkg::S_FINISH;
          endcase
        end
      end
      oaie_pkg::S_READ:     state_next = oaie_pkg::S_FINISH;
      oaie_pkg::S_SHIFT_UP: state_next = up_more ? oaie_pkg::S_SHIFT_UP : oaie_pkg::S_PUT;
      oaie_pkg::S_SHIFT_DN: state_next = dn_more ? oaie_pkg::S_SHIFT_DN : oaie_pkg::S_FINISH;
      oaie_pkg::S_PUT:      state_next = oaie_pkg::S_FINISH;
      oaie_pkg::S_FINISH:   state_next = fin_ready ? oaie_pkg::S_IDLE : oaie_pkg::S_FINISH;
      default:              state_next = oaie_pkg::S_IDLE;
    endcase
  end

  // outputs: memory requests, status and count update
  always_comb begin
    mem_req    = '0;
    count_next = count;
    status_c   = oaie_pkg::ST_OK;
    case (state)
      oaie_pkg::S_IDLE: begin
        if (accept) begin
          case (func_c)
            oaie_pkg::F_PUSH: begin
              if (full) begin
                status_c = oaie_pkg::ST_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = oaie_pkg::AW'(count);
                mem_req.wdata = request.value;
                count_next    = count + oaie_pkg::CW'(1);
              end
            end
            oaie_pkg::F_POP: begin
              if (empty) begin
                status_c = oaie_pkg::ST_EMPTY;
              end else begin
                count_next = count - oaie_pkg::CW'(1);
              end
            end
            oaie_pkg::F_INSERT: begin
              if (!idx_ok) begin
                status_c = oaie_pkg::ST_BADIDX;
              end else if (full) begin
                status_c = oaie_pkg::ST_FULL;
              end else begin
                // start from the top entry and move upward
                mem_req.re    = 1'b1;
                mem_req.raddr = oaie_pkg::AW'(count - oaie_pkg::CW'(1));
                count_next    = count + oaie_pkg::CW'(1);
              end
            end
            oaie_pkg::F_ERASE: begin
              if (!idx_ok) begin
                status_c = oaie_pkg::ST_BADIDX;
              end else begin
                mem_req.re    = erase_more;
                mem_req.raddr = oaie_pkg::AW'(pos_c + oaie_pkg::CW'(1));
                count_next    = count - oaie_pkg::CW'(1);
              end
            end
            oaie_pkg::F_READ: begin
              if (!idx_ok) begin
                status_c = oaie_pkg::ST_BADIDX;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = oaie_pkg::AW'(request.position);
              end
            end
            oaie_pkg::F_FRONT: begin
              if (empty) begin
                status_c = oaie_pkg::ST_EMPTY;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = '0;
              end
            end
            oaie_pkg::F_BACK: begin
              if (empty) begin
                status_c = oaie_pkg::ST_EMPTY;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = oaie_pkg::AW'(count - oaie_pkg::CW'(1));
              end
            end
            default: begin
              count_next = '0;
            end
          endcase
        end
      end
      oaie_pkg::S_SHIFT_UP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = addr_q + oaie_pkg::AW'(1);
        mem_req.wdata = mem_rdata;
        mem_req.re    = up_more;
        mem_req.raddr = addr_q - oaie_pkg::AW'(1);
      end
      oaie_pkg::S_SHIFT_DN: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = addr_q - oaie_pkg::AW'(1);
        mem_req.wdata = mem_rdata;
        mem_req.re    = dn_more;
        mem_req.raddr = addr_q + oaie_pkg::AW'(1);
      end
      oaie_pkg::S_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_q;
        mem_req.wdata = val_q;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  assign request.ready = state == oaie_pkg::S_IDLE;
  assign fin_valid     = state == oaie_pkg::S_FINISH;
  assign fin           = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oaie_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      addr_q <= mem_req.raddr;
    end
    if (accept) begin
      pos_q        <= oaie_pkg::AW'(request.position);
      val_q        <= request.value;
      lim_q        <= count;
      res_q.data   <= '0;
      res_q.count  <= count_next;
      res_q.status <= status_c;
    end else if (state == oaie_pkg::S_READ) begin
      res_q.data <= mem_rdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= oaie_pkg::CW'(oaie_pkg::DEPTH))
    else $error("fill count above depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("read and write to the same entry in one cycle");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && func_c == oaie_pkg::F_CLEAR) |=> (count == '0))
    else $error("clear left entries behind");

  a_read_before_use: assert property (@(posedge clk) disable iff (rst)
    (state == oaie_pkg::S_READ || state == oaie_pkg::S_SHIFT_UP ||
     state == oaie_pkg::S_SHIFT_DN) |-> $past(mem_req.re))
    else $error("memory data used without a read");

endmodule

[rtl/core/oaie_out_stage.sv]
module oaie_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           fin_valid,
  output logic           fin_ready,
  input  oaie_pkg::res_t fin,
  oaie_rsp_if.source     result
);

  logic                          valid_q;
  logic [oaie_pkg::DATA_W-1:0]   data_q;
  logic [oaie_pkg::CNT_OUT_W-1:0] count_q;
  logic [oaie_pkg::ST_W-1:0]     status_q;

  // take a new result when empty or when the held one leaves this cycle
  assign fin_ready = !valid_q || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (fin_ready) begin
      valid_q <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && fin_valid) begin
      data_q   <= fin.data;
      count_q  <= oaie_pkg::CNT_OUT_W'(fin.count);
      status_q <= fin.status;
    end
  end

  assign result.valid      = valid_q;
  assign result.read_data  = data_q;
  assign result.fill_count = count_q;
  assign result.status     = status_q;

endmodule
